[rtl/ccdr_pkg.sv]
// shared types, constants and helpers for the rank-one coordinate update core
`timescale 1ns / 1ps
`default_nettype none
package ccdr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_NNZ = 65536;
  localparam int CNT_W = 17;
  localparam int DIV_STEPS = 64 + FRAC_BITS;
  localparam int DIV_CNT_W = 7;

  // configuration register indexes
  localparam logic CFG_REG_WEIGHT = 1'b0;
  localparam logic CFG_NONNEG = 1'b1;

  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [31:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] I32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] partner_value;
    logic signed [31:0] residual;
    logic signed [31:0] old_value;
    logic empty_column;
    logic last_in_column;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic signed [63:0] objective_decrease;
    logic clamped;
    logic zero_denominator;
  } out_word_t;

  // finished column handed from front to back
  typedef struct packed {
    logic signed [63:0] g;
    logic [63:0] sq;
    logic [CNT_W-1:0] cnt;
    logic signed [31:0] old;
    logic empty;
  } job_t;

  // saturating signed 64-bit add
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return I64_MAX;
    if (a[63] && b[63] && !s[63]) return I64_MIN;
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/ccdr_fifo.sv]
// two-entry job queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module ccdr_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ccdr_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output ccdr_pkg::job_t     head
);
  import ccdr_pkg::*;

  job_t mem_r [2];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);
  assign head = mem_r[rp_r];

  // pointer and fill count
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = ~wp_r;
    if (pop) rp_nxt = ~rp_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end
endmodule
`default_nettype wire

[rtl/ccdr_front.sv]
// front end: products per nonzero and column accumulation
`timescale 1ns / 1ps
`default_nettype none
module ccdr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ccdr_pkg::in_word_t in_word,
  input  wire logic             q_full,
  output logic                  q_push,
  output ccdr_pkg::job_t        q_job
);
  import ccdr_pkg::*;

  logic s1_v_r, s1_v_nxt;
  logic signed [63:0] cr_r, sq_r;
  logic signed [31:0] old_r;
  logic last_r, empty_r;
  logic [63:0] gacc_r, gacc_nxt, sacc_r, sacc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic s1_adv, in_fire;
  logic [63:0] g_sum, s_sum;
  logic [CNT_W-1:0] cnt_inc;

  // stage one holds a closing word until the queue has room
  assign s1_adv = s1_v_r && (!(last_r || empty_r) || !q_full);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_fire = in_valid && !in_stall;

  assign g_sum = sat_add64(gacc_r, cr_r);
  assign s_sum = sat_add64(sacc_r, sq_r);
  assign cnt_inc = (cnt_r < CNT_W'(MAX_NNZ)) ? cnt_r + CNT_W'(1) : cnt_r;

  // accumulate and hand off closed columns
  always_comb begin
    s1_v_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    gacc_nxt = gacc_r;
    sacc_nxt = sacc_r;
    cnt_nxt = cnt_r;
    q_push = 1'b0;
    q_job = '{g: g_sum, sq: s_sum, cnt: cnt_inc, old: old_r, empty: empty_r};
    if (s1_adv) begin
      if (empty_r || last_r) begin
        q_push = 1'b1;
        gacc_nxt = '0;
        sacc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        gacc_nxt = g_sum;
        sacc_nxt = s_sum;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      gacc_r <= '0;
      sacc_r <= '0;
      cnt_r <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      gacc_r <= gacc_nxt;
      sacc_r <= sacc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cr_r <= in_word.partner_value * in_word.residual;
      sq_r <= in_word.partner_value * in_word.partner_value;
      old_r <= in_word.old_value;
      last_r <= in_word.last_in_column;
      empty_r <= in_word.empty_column;
    end
  end
endmodule
`default_nettype wire

[rtl/ccdr_mul.sv]
// 64x64 unsigned multiplier, one 32x32 partial product per cycle
`timescale 1ns / 1ps
`default_nettype none
module ccdr_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [127:0]     prod
);
  logic run_r;
  logic [2:0] k_r;
  logic [63:0] a_r, b_r, part_r;
  logic [1:0] psh_r;
  logic [127:0] acc_r, acc_nxt, part_sh;
  logic done_r;

  assign done = done_r;
  assign prod = acc_r;

  // place previous partial product
  always_comb begin
    unique case (psh_r)
      2'd0: part_sh = {64'd0, part_r};
      2'd1: part_sh = {32'd0, part_r, 32'd0};
      2'd2: part_sh = {part_r, 64'd0};
      default: part_sh = '0;
    endcase
    acc_nxt = (k_r != 3'd0) ? acc_r + part_sh : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      k_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        k_r <= '0;
      end else if (run_r) begin
        k_r <= k_r + 3'd1;
        if (k_r == 3'd4) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operand and partial registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      part_r <= (k_r[0] ? a_r[63:32] : a_r[31:0]) * (k_r[1] ? b_r[63:32] : b_r[31:0]);
      psh_r <= {1'b0, k_r[0]} + {1'b0, k_r[1]};
    end
  end
endmodule
`default_nettype wire

[rtl/ccdr_back.sv]
// back end: denominator, bit-serial quotient, decrease and output register
`timescale 1ns / 1ps
`default_nettype none
module ccdr_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [30:0]      reg_weight,
  input  wire logic             nonneg_mode,
  input  wire logic             q_avail,
  input  wire ccdr_pkg::job_t   q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ccdr_pkg::out_word_t   out_word
);
  import ccdr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MREG = 3'd1;
  localparam logic [2:0] ST_DIV = 3'd2;
  localparam logic [2:0] ST_MCLP = 3'd3;
  localparam logic [2:0] ST_MDD = 3'd4;
  localparam logic [2:0] ST_MHDD = 3'd5;
  localparam logic [2:0] ST_OUT = 3'd6;

  localparam int RP_TOP = 63 - FRAC_BITS;
  localparam int CL_LO = FRAC_BITS - 1;
  localparam int HD_LO = 2 * FRAC_BITS;

  logic [2:0] st_r;
  job_t job_r;
  logic [63:0] h_r;
  logic [64:0] rem_r;
  logic [DIV_STEPS-1:0] dvd_r;
  logic [32:0] q_r;
  logic ovf_r;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic neg_r;
  out_word_t res_r, out_r;
  logic out_v_r;

  logic mul_start, mul_done;
  logic [63:0] mul_a, mul_b;
  logic [127:0] mul_prod;

  logic [63:0] gmag, regpart;
  logic [64:0] hsum, rem_t;
  logic [63:0] h_val;
  logic big31, q_nz, newv_neg;
  logic [31:0] newv;
  logic signed [32:0] diff;
  logic [31:0] dmag;
  logic over_clp;
  logic [63:0] m_clp;

  assign out_valid = out_v_r;
  assign out_word = out_r;
  assign gmag = job_r.g[63] ? (64'd0 - job_r.g) : job_r.g;

  ccdr_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  // denominator from the regularization product
  always_comb begin
    regpart = (|mul_prod[127:RP_TOP]) ? I64_MAX
            : {1'b0, mul_prod[RP_TOP-1:0], {FRAC_BITS{1'b0}}};
    hsum = {1'b0, job_r.sq} + {1'b0, regpart};
    h_val = (hsum[64] || hsum[63]) ? I64_MAX : hsum[63:0];
  end

  // quotient saturation and clamp decision
  always_comb begin
    big31 = ovf_r || q_r[32] || q_r[31];
    q_nz = ovf_r || (q_r != 33'd0);
    newv_neg = job_r.g[63] && q_nz;
    if (!job_r.g[63]) newv = big31 ? I32_MAX : q_r[31:0];
    else newv = big31 ? I32_MIN : (32'd0 - q_r[31:0]);
    diff = 33'(job_r.old) - 33'($signed(newv));
    dmag = diff[32] ? 32'(-diff) : diff[31:0];
    rem_t = {rem_r[63:0], dvd_r[DIV_STEPS-1]};
  end

  // clamp-case decrease magnitude after the shift
  always_comb begin
    if (neg_r) begin
      over_clp = (|mul_prod[127:CL_LO+64]) || (mul_prod[CL_LO+63] && (|mul_prod[CL_LO+62:CL_LO]));
      m_clp = over_clp ? I64_MIN : mul_prod[CL_LO+63:CL_LO];
    end else begin
      over_clp = (|mul_prod[127:CL_LO+63]);
      m_clp = over_clp ? I64_MAX : mul_prod[CL_LO+63:CL_LO];
    end
  end

  // multiplier start and operands, and the queue pop
  always_comb begin
    mul_start = 1'b0;
    mul_a = {33'd0, reg_weight};
    mul_b = {{(64 - CNT_W){1'b0}}, q_head.cnt};
    q_pop = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (q_avail) begin
          q_pop = 1'b1;
          mul_start = !q_head.empty;
        end
      end
      ST_DIV: begin
        if (dcnt_r == DIV_CNT_W'(DIV_STEPS)) begin
          mul_start = 1'b1;
          if (nonneg_mode && newv_neg) begin
            mul_a = gmag;
            mul_b = job_r.old[31] ? {32'd0, 32'd0 - job_r.old} : {32'd0, job_r.old};
          end else begin
            mul_a = {32'd0, dmag};
            mul_b = {32'd0, dmag};
          end
        end
      end
      ST_MDD: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a = h_r;
          mul_b = mul_prod[63:0];
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (out_v_r && !out_stall) out_v_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (q_avail) st_r <= q_head.empty ? ST_OUT : ST_MREG;
        end
        ST_MREG: begin
          if (mul_done) st_r <= (h_val == 64'd0) ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (dcnt_r == DIV_CNT_W'(DIV_STEPS))
            st_r <= (nonneg_mode && newv_neg) ? ST_MCLP : ST_MDD;
        end
        ST_MCLP: begin
          if (mul_done) st_r <= ST_OUT;
        end
        ST_MDD: begin
          if (mul_done) st_r <= ST_MHDD;
        end
        ST_MHDD: begin
          if (mul_done) st_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_v_r || !out_stall) begin
            out_v_r <= 1'b1;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        if (q_avail) begin
          job_r <= q_head;
          res_r <= '0;
        end
      end
      ST_MREG: begin
        if (mul_done) begin
          h_r <= h_val;
          res_r.zero_denominator <= (h_val == 64'd0);
          rem_r <= '0;
          dvd_r <= {gmag, {FRAC_BITS{1'b0}}};
          q_r <= '0;
          ovf_r <= 1'b0;
          dcnt_r <= '0;
        end
      end
      ST_DIV: begin
        if (dcnt_r == DIV_CNT_W'(DIV_STEPS)) begin
          neg_r <= (job_r.g[63] == job_r.old[31]) && (job_r.g != 64'd0)
                   && (job_r.old != 32'd0);
          if (nonneg_mode && newv_neg) begin
            res_r.new_value <= '0;
            res_r.clamped <= 1'b1;
          end else begin
            res_r.new_value <= newv;
          end
        end else begin
          dcnt_r <= dcnt_r + DIV_CNT_W'(1);
          dvd_r <= {dvd_r[DIV_STEPS-2:0], 1'b0};
          ovf_r <= ovf_r || q_r[32];
          if (rem_t >= {1'b0, h_r}) begin
            rem_r <= rem_t - {1'b0, h_r};
            q_r <= {q_r[31:0], 1'b1};
          end else begin
            rem_r <= rem_t;
            q_r <= {q_r[31:0], 1'b0};
          end
        end
      end
      ST_MCLP: begin
        if (mul_done) res_r.objective_decrease <= neg_r ? (64'd0 - m_clp) : m_clp;
      end
      ST_MHDD: begin
        if (mul_done)
          res_r.objective_decrease <= (|mul_prod[127:HD_LO+63]) ? I64_MAX
                                    : {1'b0, mul_prod[HD_LO+62:HD_LO]};
      end
      ST_OUT: begin
        if (!out_v_r || !out_stall) out_r <= res_r;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[rtl/ccd_rank_one_coordinate_update_core.sv]
// top level of the rank-one coordinate update core
// The front end takes one nonzero word per cycle unless it stalls: the two 32x32 products are
// registered, then summed into saturating 64-bit accumulators with the column count. Each word
// that closes a column (last or empty) becomes a job in a two-entry queue. The back end serves
// one job at a time: a multiply for the regularization term (four 32x32 partial products plus
// start and finish steps), a bit-serial division (80 quotient bits, one per cycle, and a
// closing step) and one more multiply for the decrease when clamped, two otherwise, with a
// step to take the job and one to load the output word. An empty column skips the multiplies
// and the division; a zero denominator skips the division and the decrease multiplies. This
// runs while the front end keeps taking the next column's words. The front stalls only when a
// closing word finds the queue full; a stalled result holds the back end in its output step.
// Results leave through a registered output word.
`timescale 1ns / 1ps
`default_nettype none
module ccd_rank_one_coordinate_update_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ccdr_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ccdr_pkg::out_word_t      out_word,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [30:0]         cfg_wdata
);
  import ccdr_pkg::*;

  logic [30:0] reg_weight_r;
  logic nonneg_r;
  logic q_push, q_full, q_pop, q_avail;
  job_t q_job, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_weight_r <= '0;
      nonneg_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REG_WEIGHT: reg_weight_r <= cfg_wdata;
        CFG_NONNEG: nonneg_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  ccdr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word (in_word),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  ccdr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_avail),
    .head     (q_head)
  );

  ccdr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .reg_weight (reg_weight_r),
    .nonneg_mode(nonneg_r),
    .q_avail    (q_avail),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );
endmodule
`default_nettype wire

[rtl/ccdr_checker.sv]
// port-level checks for the rank-one coordinate update core
`timescale 1ns / 1ps
`default_nettype none
module ccdr_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ccdr_pkg::out_word_t out_word
);
  import ccdr_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // zero denominator forces a zero result
  a_zden: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.zero_denominator |->
      !out_word.clamped && out_word.new_value == 32'sd0 && out_word.objective_decrease == 64'sd0)
    else $error("zero denominator with nonzero result");

  // a clamped result is zero
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.clamped |-> out_word.new_value == 32'sd0)
    else $error("clamped result not zero");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind ccd_rank_one_coordinate_update_core ccdr_checker u_ccdr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
`default_nettype wire

[test/tb.sv]
// self-checking testbench for the rank-one coordinate update core
`timescale 1ns / 1ps
module tb;
  import ccdr_pkg::*;

  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int TAIL_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [30:0] cfg_wdata = '0;

  ccd_rank_one_coordinate_update_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // words waiting to be sent and updates still owed by the core
  in_word_t nonzero_q[$];
  out_word_t update_q[$];
  int send_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;

  // own copy of the column accumulators and registers
  logic [30:0] lambda_q16;
  logic nonneg_on;
  logic signed [63:0] cross_acc;
  logic signed [63:0] square_acc;
  int nnz_count;

  function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return MAX_POS;
    if (a < 0 && b < 0 && s >= 0) return ~MAX_POS;
    return s;
  endfunction

  // fold one nonzero into the column; returns 1 when a column update is due
  function automatic bit column_update(input in_word_t w, output out_word_t r);
    logic signed [63:0] u, v, old, g, h, nv, diff;
    logic [63:0] regpart, gm, om, dm, dd, cap;
    logic [127:0] wide, q;
    bit neg;
    r = '0;
    if (w.empty_column) begin
      cross_acc = 0; square_acc = 0; nnz_count = 0;
      return 1'b1;
    end
    u = w.partner_value;
    v = w.residual;
    cross_acc = add_clip(cross_acc, u * v);
    square_acc = add_clip(square_acc, u * u);
    if (nnz_count < MAX_NNZ) nnz_count++;
    if (!w.last_in_column) return 1'b0;

    old = w.old_value;
    g = cross_acc;
    wide = (128'(lambda_q16) * 128'(nnz_count)) << FRAC_BITS;
    regpart = (wide > 128'(MAX_POS)) ? MAX_POS : wide[63:0];
    h = add_clip(square_acc, regpart);
    if (h <= 0) begin
      r.zero_denominator = 1'b1;
    end else begin
      gm = g[63] ? 64'd0 - g : g;
      q = (128'(gm) << FRAC_BITS) / 128'($unsigned(h));
      if (q > 128'h1_0000_0000) q = 128'h1_0000_0000;
      if (g < 0) nv = (q >= 128'h8000_0000) ? -64'sd2147483648 : 64'd0 - q[63:0];
      else nv = (q > 128'h7FFF_FFFF) ? 64'sd2147483647 : q[63:0];
      if (nonneg_on && nv < 0) begin
        // clamped: decrease is -2*g*old
        nv = 0;
        r.clamped = 1'b1;
        om = old[63] ? 64'd0 - old : old;
        neg = (g < 0) == (old < 0) && g != 0 && old != 0;
        cap = neg ? ~MAX_POS : MAX_POS;
        wide = (128'(gm) * 128'(om)) >> (FRAC_BITS - 1);
        if (wide > 128'(cap)) wide = 128'(cap);
        r.objective_decrease = neg ? 64'd0 - wide[63:0] : wide[63:0];
      end else begin
        // h*(old-new)^2, the square wraps at 64 bits
        diff = old - nv;
        dm = diff[63] ? 64'd0 - diff : diff;
        dd = dm * dm;
        wide = (128'($unsigned(h)) * 128'(dd)) >> (2 * FRAC_BITS);
        r.objective_decrease = (wide > 128'(MAX_POS)) ? MAX_POS : wide[63:0];
      end
      r.new_value = nv[31:0];
    end
    cross_acc = 0; square_acc = 0; nnz_count = 0;
    return 1'b1;
  endfunction

  // driver: predict on acceptance, then present the next word or idle
  always @(posedge clk) begin : drive_blk
    out_word_t upd;
    if (rst_n) begin
      if (in_valid && !in_stall && column_update(in_word, upd)) update_q.push_back(upd);
      if (!in_valid || !in_stall) begin
        if (nonzero_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_word <= nonzero_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string what, input logic [63:0] e, input logic [63:0] a);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h actual %h", what, e, a);
  endtask

  // monitor: compare each update with the oldest prediction
  always @(posedge clk) begin : watch_blk
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (update_q.size() == 0) begin
          note_mismatch("unexpected word", 64'd0, out_word.objective_decrease);
        end else begin
          want = update_q.pop_front();
          if (out_word.new_value !== want.new_value)
            note_mismatch("new_value", want.new_value, out_word.new_value);
          if (out_word.objective_decrease !== want.objective_decrease)
            note_mismatch("objective_decrease", want.objective_decrease,
                          out_word.objective_decrease);
          if (out_word.clamped !== want.clamped)
            note_mismatch("clamped", want.clamped, out_word.clamped);
          if (out_word.zero_denominator !== want.zero_denominator)
            note_mismatch("zero_denominator", want.zero_denominator,
                          out_word.zero_denominator);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // mix of extremes, small and full-range Q16.16 values
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(5))
      0: return $urandom;
      1: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          3: return 32'h1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      2: return $urandom_range(32'h3FFFF) * ($urandom_range(1) ? 1 : -1);
      default: return $urandom_range(32'h1FF_FFFF) * ($urandom_range(1) ? 1 : -1);
    endcase
  endfunction

  function automatic in_word_t make_word(input logic [31:0] u, input logic [31:0] v,
                                         input logic [31:0] old, input bit empty,
                                         input bit last);
    in_word_t w;
    w.partner_value = u;
    w.residual = v;
    w.old_value = old;
    w.empty_column = empty;
    w.last_in_column = last;
    return w;
  endfunction

  task automatic add_column(input int n, input bit close, input bit zero_u);
    for (int i = 0; i < n; i++)
      nonzero_q.push_back(make_word(zero_u ? 32'h0 : pick_q16(), pick_q16(), pick_q16(),
                                    1'b0, close && (i == n - 1)));
  endtask

  task automatic add_random(input int count);
    int k;
    int n;
    k = 0;
    while (k < count) begin
      k++;
      case ($urandom_range(99)) inside
        [0:5]: begin
          // partial column thrown away by an empty word
          n = $urandom_range(1, 4);
          add_column(n, 1'b0, 1'b0);
          nonzero_q.push_back(make_word($urandom, $urandom, $urandom, 1'b1,
                                        1'($urandom_range(1))));
          k += n;
        end
        [6:9]: nonzero_q.push_back(make_word($urandom, $urandom, $urandom, 1'b1,
                                             1'($urandom_range(1))));
        [10:14]: begin
          n = $urandom_range(1, 3);
          add_column(n, 1'b1, 1'b1);
          k += n - 1;
        end
        [15:22]: begin
          n = $urandom_range(20, 60);
          add_column(n, 1'b1, 1'b0);
          k += n - 1;
        end
        default: begin
          n = $urandom_range(1, 6);
          add_column(n, 1'b1, 1'b0);
          k += n - 1;
        end
      endcase
    end
  endtask

  // let the core drain and finish its last column
  task automatic drain();
    do @(posedge clk); while (nonzero_q.size() != 0 || in_valid || update_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_REG_WEIGHT) lambda_q16 = val;
    else nonneg_on = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    lambda_q16 = '0;
    nonneg_on = 1'b0;
    cross_acc = 0;
    square_acc = 0;
    nnz_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      send_idle = (p < 2) ? 27 : (p < 4) ? 68 : 0;
      recv_idle = (p < 2) ? 68 : (p < 4) ? 27 : 0;
      case (p)
        0: begin write_reg(CFG_REG_WEIGHT, 31'd0); write_reg(CFG_NONNEG, 31'd1); end
        1: begin write_reg(CFG_REG_WEIGHT, 31'h7FFF_FFFF); write_reg(CFG_NONNEG, 31'd0); end
        2: begin write_reg(CFG_REG_WEIGHT, 31'($urandom)); write_reg(CFG_NONNEG, 31'd1); end
        3: begin write_reg(CFG_REG_WEIGHT, 31'h1_0000); write_reg(CFG_NONNEG, 31'd0); end
        4: begin
          write_reg(CFG_REG_WEIGHT, 31'($urandom_range(31'h100)));
          write_reg(CFG_NONNEG, 31'd1);
        end
        default: begin write_reg(CFG_REG_WEIGHT, 31'd1); write_reg(CFG_NONNEG, 31'd0); end
      endcase

      if (p == 0) begin
        // directed: empty, zero h, extremes, clamping both signs, saturating sums
        nonzero_q.push_back(make_word(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1));
        nonzero_q.push_back(make_word(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1));
        nonzero_q.push_back(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1));
        nonzero_q.push_back(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1));
        nonzero_q.push_back(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1));
        nonzero_q.push_back(make_word(32'h1, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1));
        nonzero_q.push_back(make_word(32'h100, 32'h8000_0001, 32'h0, 1'b0, 1'b1));
        for (int i = 0; i < 3; i++)
          nonzero_q.push_back(make_word(32'h8000_0000, 32'h8000_0000, 32'h1_0000, 1'b0, i == 2));
        for (int i = 0; i < 3; i++)
          nonzero_q.push_back(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b0, i == 2));
        nonzero_q.push_back(make_word(32'h3_0000, 32'h2_0000, 32'h0, 1'b0, 1'b0));
        nonzero_q.push_back(make_word(32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
        nonzero_q.push_back(make_word(32'h1_0000, 32'h1_0000, 32'hFFFF_FFFF, 1'b0, 1'b1));
        drain();
        write_reg(CFG_NONNEG, 31'd0);
        nonzero_q.push_back(make_word(32'h100, 32'h8000_0001, 32'h0, 1'b0, 1'b1));
        nonzero_q.push_back(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1));
      end

      add_random(50);
      // hold the sender until every update has come back
      if (p == 1) drain();
      add_random(50);
      drain();
    end

    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("tb failed");
    $finish;
  end

endmodule
